// ===== rtl/core/btlpm_pkg.sv =====
// Shared types and constants for the binary trie route lookup block.
`default_nettype none

package btlpm_pkg;

    localparam int ADDR_BITS = 32;
    localparam int HOP_W     = 32;
    localparam int PORT_W    = 8;
    localparam int PLEN_W    = 6;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic              found;
        logic [HOP_W-1:0]  hop_addr;
        logic [PORT_W-1:0] port_out;
        logic              pool_full;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/btlpm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module btlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/btlpm_walk.sv =====
// Trie walker: command sequencer, root node registers, node allocation and memory access.
`default_nettype none

module btlpm_walk #(
    parameter int TRIE_NODES = 4096,
    parameter int PORT_BITS  = 8
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire logic                                          command,
    input  wire logic [btlpm_pkg::ADDR_BITS-1:0]               address,
    input  wire logic [btlpm_pkg::PLEN_W-1:0]                  prefix_len,
    input  wire logic [btlpm_pkg::HOP_W-1:0]                   gateway,
    input  wire logic [btlpm_pkg::PORT_W-1:0]                  out_port,
    output logic                                               res_valid,
    input  wire logic                                          res_take,
    output btlpm_pkg::res_t                                    res,
    output logic [$clog2(TRIE_NODES)-1:0]                      rd_addr,
    input  wire logic [2*$clog2(TRIE_NODES)-1:0]               child_rdata,
    input  wire logic [btlpm_pkg::HOP_W+
                       ((PORT_BITS < btlpm_pkg::PORT_W) ? PORT_BITS
                                                         : btlpm_pkg::PORT_W):0] route_rdata,
    output logic                                               child_we,
    output logic [$clog2(TRIE_NODES)-1:0]                      child_waddr,
    output logic [2*$clog2(TRIE_NODES)-1:0]                    child_wdata,
    output logic                                               route_we,
    output logic [$clog2(TRIE_NODES)-1:0]                      route_waddr,
    output logic [btlpm_pkg::HOP_W+
                  ((PORT_BITS < btlpm_pkg::PORT_W) ? PORT_BITS
                                                    : btlpm_pkg::PORT_W):0] route_wdata
);

    localparam int NW    = $clog2(TRIE_NODES);
    localparam int CNT_W = $clog2(TRIE_NODES + 1);
    localparam int AB    = btlpm_pkg::ADDR_BITS;
    localparam int HW    = btlpm_pkg::HOP_W;
    localparam int PW    = btlpm_pkg::PORT_W;
    localparam int LW    = btlpm_pkg::PLEN_W;
    localparam int PB    = (PORT_BITS < PW) ? PORT_BITS : PW;
    localparam int CW    = 2 * NW;
    localparam int RW    = 1 + HW + PB;

    btlpm_pkg::state_t state_reg, state_next;

    logic            cmd_reg,        cmd_next;
    logic [AB-1:0]   addr_reg,       addr_next;
    logic [LW-1:0]   plen_reg,       plen_next;
    logic [HW-1:0]   hop_reg,        hop_next;
    logic [PB-1:0]   port_reg,       port_next;
    logic [NW-1:0]   node_reg,       node_next;
    logic [LW-1:0]   depth_reg,      depth_next;
    logic            fresh_reg,      fresh_next;
    logic [CNT_W-1:0] used_reg,      used_next;
    logic            best_hit_reg,   best_hit_next;
    logic [HW-1:0]   best_hop_reg,   best_hop_next;
    logic [PB-1:0]   best_port_reg,  best_port_next;
    btlpm_pkg::res_t res_reg,        res_next;
    logic [NW-1:0]   root_left_reg,  root_left_next;
    logic [NW-1:0]   root_right_reg, root_right_next;
    logic            root_valid_reg, root_valid_next;
    logic [HW-1:0]   root_hop_reg,   root_hop_next;
    logic [PB-1:0]   root_port_reg,  root_port_next;

    logic            at_root;
    logic            lookup;
    logic [NW-1:0]   cur_left;
    logic [NW-1:0]   cur_right;
    logic            cur_valid;
    logic [HW-1:0]   cur_hop;
    logic [PB-1:0]   cur_port;
    logic            dbit;
    logic [NW-1:0]   slot;
    logic            pool_empty;
    logic [NW-1:0]   new_node;
    logic [LW-1:0]   plen_sat;
    logic            is_last;
    logic            walk_done;
    logic            eff_hit;
    logic [HW-1:0]   eff_hop;
    logic [PB-1:0]   eff_port;
    logic [CW-1:0]   link_entry;

    // The root lives in flip-flops so that reset can clear it; every other node
    // is read from the memories in the cycle after its address is issued. Nodes
    // allocated during the current insert are known to be empty; their child links are not read.
    always_comb
    begin
        at_root    = (node_reg == '0);
        lookup     = (cmd_reg == btlpm_pkg::CMD_LOOKUP);
        cur_left   = fresh_reg ? '0 : (at_root ? root_left_reg  : child_rdata[NW-1:0]);
        cur_right  = fresh_reg ? '0 : (at_root ? root_right_reg : child_rdata[CW-1:NW]);
        cur_valid  = at_root ? root_valid_reg : route_rdata[RW-1];
        cur_hop    = at_root ? root_hop_reg   : route_rdata[RW-2:PB];
        cur_port   = at_root ? root_port_reg  : route_rdata[PB-1:0];
        dbit       = addr_reg[AB-1];
        slot       = dbit ? cur_right : cur_left;
        pool_empty = (used_reg == CNT_W'(TRIE_NODES));
        new_node   = used_reg[NW-1:0];
        plen_sat   = (prefix_len > LW'(AB)) ? LW'(AB) : prefix_len;
        is_last    = lookup ? (depth_reg == LW'(AB)) : (depth_reg == plen_reg);
        walk_done  = lookup ? (is_last || (slot == '0))
                            : (is_last || ((slot == '0) && pool_empty));
        eff_hit    = best_hit_reg | cur_valid;
        eff_hop    = cur_valid ? cur_hop  : best_hop_reg;
        eff_port   = cur_valid ? cur_port : best_port_reg;
        link_entry = dbit ? {new_node, cur_left} : {cur_right, new_node};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btlpm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = btlpm_pkg::ST_WALK;
                end
            end
            btlpm_pkg::ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = btlpm_pkg::ST_HOLD;
                end
            end
            btlpm_pkg::ST_HOLD:
            begin
                if (res_take)
                begin
                    state_next = btlpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btlpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == btlpm_pkg::ST_IDLE);
        res_valid = (state_reg == btlpm_pkg::ST_HOLD);
        res       = res_reg;
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        plen_next       = plen_reg;
        hop_next        = hop_reg;
        port_next       = port_reg;
        node_next       = node_reg;
        depth_next      = depth_reg;
        fresh_next      = fresh_reg;
        used_next       = used_reg;
        best_hit_next   = best_hit_reg;
        best_hop_next   = best_hop_reg;
        best_port_next  = best_port_reg;
        res_next        = res_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        root_valid_next = root_valid_reg;
        root_hop_next   = root_hop_reg;
        root_port_next  = root_port_reg;
        rd_addr         = slot;
        child_we        = 1'b0;
        child_waddr     = node_reg;
        child_wdata     = '0;
        route_we        = 1'b0;
        route_waddr     = node_reg;
        route_wdata     = '0;

        unique case (state_reg)
            btlpm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = command;
                    addr_next      = address;
                    plen_next      = plen_sat;
                    hop_next       = gateway;
                    port_next      = out_port[PB-1:0];
                    node_next      = '0;
                    depth_next     = '0;
                    fresh_next     = 1'b0;
                    best_hit_next  = 1'b0;
                    best_hop_next  = '0;
                    best_port_next = '0;
                end
            end
            btlpm_pkg::ST_WALK:
            begin
                if (lookup)
                begin
                    best_hit_next  = eff_hit;
                    best_hop_next  = eff_hop;
                    best_port_next = eff_port;
                    if (walk_done)
                    begin
                        res_next.found     = eff_hit;
                        res_next.hop_addr  = eff_hop;
                        res_next.port_out  = PW'(eff_port);
                        res_next.pool_full = 1'b0;
                    end
                    else
                    begin
                        node_next  = slot;
                        depth_next = depth_reg + LW'(1);
                        addr_next  = addr_reg << 1;
                    end
                end
                else
                begin
                    priority if (is_last)
                    begin
                        // End of the prefix: store the route; a node made by this
                        // insert also gets its empty child links written here.
                        if (at_root)
                        begin
                            root_valid_next = 1'b1;
                            root_hop_next   = hop_reg;
                            root_port_next  = port_reg;
                        end
                        else
                        begin
                            route_we    = 1'b1;
                            route_wdata = {1'b1, hop_reg, port_reg};
                            child_we    = fresh_reg;
                        end
                        res_next.found     = 1'b1;
                        res_next.hop_addr  = '0;
                        res_next.port_out  = '0;
                        res_next.pool_full = 1'b0;
                    end
                    else if (slot != '0)
                    begin
                        node_next  = slot;
                        depth_next = depth_reg + LW'(1);
                        addr_next  = addr_reg << 1;
                    end
                    else if (pool_empty)
                    begin
                        child_we           = fresh_reg;
                        res_next.found     = 1'b0;
                        res_next.hop_addr  = '0;
                        res_next.port_out  = '0;
                        res_next.pool_full = 1'b1;
                    end
                    else
                    begin
                        if (at_root)
                        begin
                            root_left_next  = link_entry[NW-1:0];
                            root_right_next = link_entry[CW-1:NW];
                        end
                        else
                        begin
                            child_we    = 1'b1;
                            child_wdata = link_entry;
                        end
                        route_we    = 1'b1;
                        route_waddr = new_node;
                        route_wdata = '0;
                        used_next   = used_reg + CNT_W'(1);
                        node_next   = new_node;
                        fresh_next  = 1'b1;
                        depth_next  = depth_reg + LW'(1);
                        addr_next   = addr_reg << 1;
                    end
                end
            end
            btlpm_pkg::ST_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= btlpm_pkg::ST_IDLE;
            cmd_reg        <= btlpm_pkg::CMD_LOOKUP;
            node_reg       <= '0;
            depth_reg      <= '0;
            fresh_reg      <= 1'b0;
            used_reg       <= CNT_W'(1);
            root_left_reg  <= '0;
            root_right_reg <= '0;
            root_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            node_reg       <= node_next;
            depth_reg      <= depth_next;
            fresh_reg      <= fresh_next;
            used_reg       <= used_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            root_valid_reg <= root_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        plen_reg      <= plen_next;
        hop_reg       <= hop_next;
        port_reg      <= port_next;
        best_hit_reg  <= best_hit_next;
        best_hop_reg  <= best_hop_next;
        best_port_reg <= best_port_next;
        res_reg       <= res_next;
        root_hop_reg  <= root_hop_next;
        root_port_reg <= root_port_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/binary_trie_longest_prefix_match.sv =====
// Top level of the IPv4 longest prefix match route table held as a binary trie.
//
//   Channel   Handshake            Word
//   in        in_valid/in_ready    command, address, prefix_len, gateway, out_port
//   out       out_valid/out_ready  found, hop_addr, port_out, pool_full
//
// An item is accepted in the idle state, then walks the trie one level at a time, and its
// result is held in the walker until the output register takes it.
// The walk issues one child memory read per level.
// Reset clears the root node and the node count; no memory clearing pass is needed.
// A new word is accepted as soon as the previous result has moved to the output
// register, even while that result is stalled.
`default_nettype none

module binary_trie_longest_prefix_match #(
    parameter int TRIE_NODES = 4096,
    parameter int PORT_BITS  = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [31:0] address,
    input  wire logic [5:0]  prefix_len,
    input  wire logic [31:0] gateway,
    input  wire logic [7:0]  out_port,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [31:0]      hop_addr,
    output logic [7:0]       port_out,
    output logic             pool_full
);

    localparam int NW = $clog2(TRIE_NODES);
    localparam int PB = (PORT_BITS < btlpm_pkg::PORT_W) ? PORT_BITS : btlpm_pkg::PORT_W;
    localparam int CW = 2 * NW;
    localparam int RW = 1 + btlpm_pkg::HOP_W + PB;

    logic            res_valid;
    logic            res_take;
    btlpm_pkg::res_t res;
    logic [NW-1:0]   rd_addr;
    logic [CW-1:0]   child_rdata;
    logic [RW-1:0]   route_rdata;
    logic            child_we;
    logic [NW-1:0]   child_waddr;
    logic [CW-1:0]   child_wdata;
    logic            route_we;
    logic [NW-1:0]   route_waddr;
    logic [RW-1:0]   route_wdata;

    logic            out_valid_reg, out_valid_next;
    btlpm_pkg::res_t out_reg,       out_next;

    btlpm_walk #(
        .TRIE_NODES (TRIE_NODES),
        .PORT_BITS  (PORT_BITS)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .address     (address),
        .prefix_len  (prefix_len),
        .gateway     (gateway),
        .out_port    (out_port),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .rd_addr     (rd_addr),
        .child_rdata (child_rdata),
        .route_rdata (route_rdata),
        .child_we    (child_we),
        .child_waddr (child_waddr),
        .child_wdata (child_wdata),
        .route_we    (route_we),
        .route_waddr (route_waddr),
        .route_wdata (route_wdata)
    );

    btlpm_ram #(
        .WIDTH (CW),
        .DEPTH (TRIE_NODES)
    ) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .raddr (rd_addr),
        .rdata (child_rdata)
    );

    btlpm_ram #(
        .WIDTH (RW),
        .DEPTH (TRIE_NODES)
    ) u_route_ram (
        .clk   (clk),
        .we    (route_we),
        .waddr (route_waddr),
        .wdata (route_wdata),
        .raddr (rd_addr),
        .rdata (route_rdata)
    );

    // The output register takes a finished result when it is empty or being drained.
    always_comb
    begin
        res_take       = res_valid && (!out_valid_reg || out_ready);
        out_next       = res_take ? res : out_reg;
        out_valid_next = res_take ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = out_reg.found;
    assign hop_addr  = out_reg.hop_addr;
    assign port_out  = out_reg.port_out;
    assign pool_full = out_reg.pool_full;

endmodule

`default_nettype wire

// ===== rtl/core/btlpm_checker.sv =====
// Port-level checker for the trie route table, bound to the top level.
`default_nettype none

module btlpm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        found,
    input wire logic [31:0] hop_addr,
    input wire logic [7:0]  port_out,
    input wire logic        pool_full
);

    // Only one word is in the walk at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a walk is in progress");

    // A failed insert reports nothing but the full flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pool_full) |-> (!found && hop_addr == 32'd0 && port_out == 8'd0))
        else $error("pool full result carries route data");

    // A miss or a failed insert returns zero next hop and port.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (hop_addr == 32'd0 && port_out == 8'd0))
        else $error("result without a match carries route data");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hop_addr) && $stable(found)))
        else $error("stalled result word changed");

endmodule

bind binary_trie_longest_prefix_match btlpm_checker u_btlpm_checker (.*);

`default_nettype wire
